// ----- rtl/core/pf_pkg.sv -----
// ----------------------------------------------------------------------------
// pf_pkg: shared definitions for the prime factorizer
// Field widths, microcode encodings and the sequencer program ROM.
// ----------------------------------------------------------------------------
package pf_pkg;

   localparam int NUMBER_BITS_DEFAULT = 31;
   localparam int REQ_BITS            = 31;
   localparam int FACTOR_BITS         = 31;
   localparam int POS_BITS            = 5;
   localparam int MAX_RESULTS         = 30;
   localparam int PC_BITS             = 5;

   typedef logic [PC_BITS-1:0] pc_type;

   // datapath action of one step
   typedef enum logic [2:0] {
      ACT_NOP       = 3'd0,
      ACT_LOAD      = 3'd1,
      ACT_DIV_START = 3'd2,
      ACT_DIV_STEP  = 3'd3,
      ACT_EMIT_DIV  = 3'd4,
      ACT_EMIT_REM  = 3'd5,
      ACT_EMIT_NONE = 3'd6,
      ACT_INC_DIV   = 3'd7
   } act_type;

   // jump condition of one step: taken -> target, else fall through
   typedef enum logic [3:0] {
      C_NEVER    = 4'd0,
      C_ALWAYS   = 4'd1,
      C_NO_REQ   = 4'd2,
      C_REM_LT2  = 4'd3,
      C_DIV_BUSY = 4'd4,
      C_DIV_GT_Q = 4'd5,
      C_REM_NZ   = 4'd6,
      C_CNT_MAX  = 4'd7,
      C_RSP_WAIT = 4'd8,
      C_QUO_EQ1  = 4'd9
   } cond_type;

   typedef struct packed {
      act_type  act;
      cond_type cond;
      pc_type   target;
   } uop_type;

   // program step addresses
   localparam pc_type S_WAIT      = 5'd0;
   localparam pc_type S_CHECK     = 5'd1;
   localparam pc_type S_OSTART    = 5'd2;
   localparam pc_type S_ORUN      = 5'd3;
   localparam pc_type S_OTEST     = 5'd4;
   localparam pc_type S_ITEST     = 5'd5;
   localparam pc_type S_ICOUNT    = 5'd6;
   localparam pc_type S_EMIT_DIV  = 5'd7;
   localparam pc_type S_ILAST     = 5'd8;
   localparam pc_type S_ISTART    = 5'd9;
   localparam pc_type S_IRUN      = 5'd10;
   localparam pc_type S_IBACK     = 5'd11;
   localparam pc_type S_INC       = 5'd12;
   localparam pc_type S_EMIT_REM  = 5'd13;
   localparam pc_type S_REM_DONE  = 5'd14;
   localparam pc_type S_EMIT_NONE = 5'd15;
   localparam pc_type S_NONE_DONE = 5'd16;

   function automatic uop_type rom_read(input pc_type pc);
      uop_type u;
      case (pc)
         S_WAIT:      u = '{ACT_LOAD,      C_NO_REQ,   S_WAIT};
         S_CHECK:     u = '{ACT_NOP,       C_REM_LT2,  S_EMIT_NONE};
         S_OSTART:    u = '{ACT_DIV_START, C_NEVER,    S_WAIT};
         S_ORUN:      u = '{ACT_DIV_STEP,  C_DIV_BUSY, S_ORUN};
         S_OTEST:     u = '{ACT_NOP,       C_DIV_GT_Q, S_EMIT_REM};
         S_ITEST:     u = '{ACT_NOP,       C_REM_NZ,   S_INC};
         S_ICOUNT:    u = '{ACT_NOP,       C_CNT_MAX,  S_EMIT_REM};
         S_EMIT_DIV:  u = '{ACT_EMIT_DIV,  C_RSP_WAIT, S_EMIT_DIV};
         S_ILAST:     u = '{ACT_NOP,       C_QUO_EQ1,  S_WAIT};
         S_ISTART:    u = '{ACT_DIV_START, C_NEVER,    S_WAIT};
         S_IRUN:      u = '{ACT_DIV_STEP,  C_DIV_BUSY, S_IRUN};
         S_IBACK:     u = '{ACT_NOP,       C_ALWAYS,   S_ITEST};
         S_INC:       u = '{ACT_INC_DIV,   C_ALWAYS,   S_OSTART};
         S_EMIT_REM:  u = '{ACT_EMIT_REM,  C_RSP_WAIT, S_EMIT_REM};
         S_REM_DONE:  u = '{ACT_NOP,       C_ALWAYS,   S_WAIT};
         S_EMIT_NONE: u = '{ACT_EMIT_NONE, C_RSP_WAIT, S_EMIT_NONE};
         S_NONE_DONE: u = '{ACT_NOP,       C_ALWAYS,   S_WAIT};
         default:     u = '{ACT_NOP,       C_ALWAYS,   S_WAIT};
      endcase
      return u;
   endfunction

endpackage

// ----- rtl/core/prime_factorizer.sv -----
// ----------------------------------------------------------------------------
// prime_factorizer: trial-division prime factorization
// Microcoded sequencer over a restoring divider; one number in, a run of
// ascending prime factors out.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: one transaction carries req_number; the low NUMBER_BITS bits
//    are factored. req_ready is high only while the sequencer is idle, so one
//    number is in flight at a time.
//  - rsp channel: one transaction per prime factor, ascending, with repeats.
//    rsp_position counts from 0 within the run, rsp_last marks its end.
//    Inputs 0 and 1 give one transaction with rsp_none set and factor 0.
//  - Cost: each trial divisor takes one division by the bit-serial restoring
//    divider (one quotient bit per cycle) plus the start, test and increment
//    steps; each factor found costs one more division.
//  - A stalled receiver holds the sequencer on the emit step; the payload
//    stays stable and no work proceeds until the result is taken.
//  - Synchronous reset returns the program counter to the idle step; a run
//    in progress is dropped.
// ----------------------------------------------------------------------------
module prime_factorizer
   import pf_pkg::*;
#(
   parameter int NUMBER_BITS = NUMBER_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [REQ_BITS-1:0]    req_number,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [FACTOR_BITS-1:0] rsp_factor,
   output logic [POS_BITS-1:0]    rsp_position,
   output logic                   rsp_last,
   output logic                   rsp_none
);

   localparam int CNT_BITS = $clog2(NUMBER_BITS + 1);
   localparam logic [POS_BITS-1:0] POS_MAX = POS_BITS'(MAX_RESULTS - 1);

   // sequencer
   pc_type  pc_ff, pc_in;
   uop_type uop;

   // datapath registers
   logic [NUMBER_BITS-1:0] rem_ff, rem_in;    // remaining quotient
   logic [NUMBER_BITS-1:0] div_ff, div_in;    // trial divisor
   logic [POS_BITS-1:0]    cnt_ff, cnt_in;    // results emitted so far
   // divider: quo_ff shifts the dividend out and the quotient in
   logic [NUMBER_BITS-1:0] quo_ff, quo_in;
   logic [NUMBER_BITS-1:0] par_ff, par_in;    // partial remainder
   logic [CNT_BITS-1:0]    bit_ff, bit_in;    // bits left

   logic [NUMBER_BITS-1:0] number_ext;
   logic [NUMBER_BITS:0]   shifted;
   logic [NUMBER_BITS:0]   trial;
   logic                   cond_hit;
   logic                   req_fire;
   logic                   rsp_fire;
   logic [NUMBER_BITS-1:0] out_value;

   // width adaption between fixed ports and NUMBER_BITS
   for (genvar i = 0; i < NUMBER_BITS; i++) begin : g_in
      if (i < REQ_BITS) begin : g_bit
         assign number_ext[i] = req_number[i];
      end else begin : g_zero
         assign number_ext[i] = 1'b0;
      end
   end

   for (genvar i = 0; i < FACTOR_BITS; i++) begin : g_out
      if (i < NUMBER_BITS) begin : g_bit
         assign rsp_factor[i] = out_value[i];
      end else begin : g_zero
         assign rsp_factor[i] = 1'b0;
      end
   end

   assign uop = rom_read(pc_ff);

   assign req_ready = (uop.act == ACT_LOAD);
   assign rsp_valid = (uop.act == ACT_EMIT_DIV) || (uop.act == ACT_EMIT_REM) ||
                      (uop.act == ACT_EMIT_NONE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;

   // result payload
   always_comb begin
      out_value    = '0;
      rsp_last     = 1'b0;
      rsp_none     = 1'b0;
      rsp_position = cnt_ff;
      case (uop.act)
         ACT_EMIT_DIV: begin
            out_value = div_ff;
            rsp_last  = (quo_ff == NUMBER_BITS'(1));  // quotient left is 1
         end
         ACT_EMIT_REM: begin
            out_value = rem_ff;
            rsp_last  = 1'b1;
         end
         ACT_EMIT_NONE: begin
            rsp_last = 1'b1;
            rsp_none = 1'b1;
         end
         default: begin
            out_value = '0;
         end
      endcase
   end

   // one restoring step
   assign shifted = {par_ff, quo_ff[NUMBER_BITS-1]};
   assign trial   = shifted - {1'b0, div_ff};

   // jump conditions
   always_comb begin
      case (uop.cond)
         C_NEVER:    cond_hit = 1'b0;
         C_ALWAYS:   cond_hit = 1'b1;
         C_NO_REQ:   cond_hit = !req_valid;
         C_REM_LT2:  cond_hit = (rem_ff < NUMBER_BITS'(2));
         C_DIV_BUSY: cond_hit = (bit_ff != CNT_BITS'(1));
         C_DIV_GT_Q: cond_hit = (div_ff > quo_ff);
         C_REM_NZ:   cond_hit = (par_ff != '0);
         C_CNT_MAX:  cond_hit = (cnt_ff == POS_MAX);
         C_RSP_WAIT: cond_hit = !rsp_ready;
         C_QUO_EQ1:  cond_hit = (rem_ff == NUMBER_BITS'(1));
         default:    cond_hit = 1'b0;
      endcase
   end

   assign pc_in = cond_hit ? uop.target : pc_ff + pc_type'(1);

   // datapath
   always_comb begin
      rem_in = rem_ff;
      div_in = div_ff;
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      par_in = par_ff;
      bit_in = bit_ff;
      case (uop.act)
         ACT_LOAD: begin
            if (req_fire) begin
               rem_in = number_ext;
               div_in = NUMBER_BITS'(2);
               cnt_in = '0;
            end
         end
         ACT_DIV_START: begin
            quo_in = rem_ff;
            par_in = '0;
            bit_in = CNT_BITS'(NUMBER_BITS);
         end
         ACT_DIV_STEP: begin
            if (trial[NUMBER_BITS]) begin
               par_in = shifted[NUMBER_BITS-1:0];
               quo_in = {quo_ff[NUMBER_BITS-2:0], 1'b0};
            end else begin
               par_in = trial[NUMBER_BITS-1:0];
               quo_in = {quo_ff[NUMBER_BITS-2:0], 1'b1};
            end
            bit_in = bit_ff - CNT_BITS'(1);
         end
         ACT_EMIT_DIV: begin
            if (rsp_fire) begin
               cnt_in = cnt_ff + POS_BITS'(1);
               rem_in = quo_ff;
            end
         end
         ACT_INC_DIV: begin
            div_in = div_ff + NUMBER_BITS'(1);
         end
         default: begin
            rem_in = rem_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= S_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      par_ff <= par_in;
      bit_ff <= bit_in;
   end

   // checks
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request accepted while a result is pending");

   a_none_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_none) |-> (rsp_last && rsp_position == '0 && rsp_factor == '0))
      else $error("malformed no-factor result");

   a_run_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> (rsp_position != POS_MAX))
      else $error("run exceeds the result limit");

   a_pos_advance: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && !rsp_last) |=> (cnt_ff == $past(cnt_ff) + POS_BITS'(1)))
      else $error("position did not advance after a result");

   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == S_OTEST) |-> (par_ff < div_ff))
      else $error("divider remainder not below divisor");

endmodule
